[design/t9kc_pkg.sv]
// shared types, constants and helper functions of the t9 keypad candidate collector
// no dependencies; imported by every module of the block
package t9kc_pkg;

   localparam int MAX_CANDIDATES_DEF = 32;
   localparam int MAX_SPELLING       = 6;
   localparam int KEY_DIGITS         = 6;

   // register map, word index taken from paddr[3:2]
   localparam logic [1:0] CSR_KEY_DIGITS  = 2'd0;
   localparam logic [1:0] CSR_KEY_LENGTH  = 2'd1;
   localparam logic [1:0] CSR_CHAR_LIMIT  = 2'd2;
   localparam logic [1:0] CSR_BYTE_BUDGET = 2'd3;

   localparam logic [5:0] CHAR_LIMIT_RST  = 6'd32;
   localparam logic [7:0] BYTE_BUDGET_RST = 8'd64;

   localparam logic        ACTION_CLEAR = 1'b0;
   localparam logic        ACTION_OFFER = 1'b1;

   localparam logic [7:0] CH_UPPER_A = "A";
   localparam logic [7:0] CH_UPPER_Z = "Z";
   localparam logic [7:0] CH_LOWER_A = "a";
   localparam logic [7:0] CH_LOWER_Z = "z";
   localparam logic [7:0] CH_C = "c";
   localparam logic [7:0] CH_F = "f";
   localparam logic [7:0] CH_I = "i";
   localparam logic [7:0] CH_L = "l";
   localparam logic [7:0] CH_O = "o";
   localparam logic [7:0] CH_S = "s";
   localparam logic [7:0] CH_V = "v";

   localparam logic [20:0] UTF8_ONE_LIMIT   = 21'h80;
   localparam logic [20:0] UTF8_TWO_LIMIT   = 21'h800;
   localparam logic [20:0] UTF8_THREE_LIMIT = 21'h10000;

   // registered output of the lane stage
   typedef struct packed {
      logic        action;
      logic [20:0] glyph;
      logic        match;
      logic        dup;
      logic [2:0]  utf8_len;
   } lane_result_type;

   // one result item
   typedef struct packed {
      logic        taken;
      logic [20:0] glyph_out;
      logic [4:0]  slot;
      logic [5:0]  char_count;
      logic [7:0]  bytes_used;
      logic        budget_stop;
   } result_type;

   // keypad digit of an ascii letter, zero for anything else
   function automatic logic [3:0] letter_digit(input logic [7:0] ch);
      logic [7:0] lc;
      logic [3:0] d;
      lc = ch;
      if (ch inside {[CH_UPPER_A:CH_UPPER_Z]}) begin
         lc = ch - CH_UPPER_A + CH_LOWER_A;
      end
      if (!(lc inside {[CH_LOWER_A:CH_LOWER_Z]})) d = 4'd0;
      else if (lc <= CH_C) d = 4'd2;
      else if (lc <= CH_F) d = 4'd3;
      else if (lc <= CH_I) d = 4'd4;
      else if (lc <= CH_L) d = 4'd5;
      else if (lc <= CH_O) d = 4'd6;
      else if (lc <= CH_S) d = 4'd7;
      else if (lc <= CH_V) d = 4'd8;
      else d = 4'd9;
      return d;
   endfunction

   // encoded length; anything past the unicode range counts as four bytes
   function automatic logic [2:0] utf8_length(input logic [20:0] cp);
      logic [2:0] n;
      if (cp < UTF8_ONE_LIMIT) n = 3'd1;
      else if (cp < UTF8_TWO_LIMIT) n = 3'd2;
      else if (cp < UTF8_THREE_LIMIT) n = 3'd3;
      else n = 3'd4;
      return n;
   endfunction

endpackage

[design/t9kc_key_match.sv]
// spelling match lanes: one lane per key digit maps a letter and compares it
// depends on t9kc_pkg (letter_digit, KEY_DIGITS, MAX_SPELLING)
module t9kc_key_match
   import t9kc_pkg::*;
(
   input  logic [23:0] key_digits,
   input  logic [2:0]  key_length,
   input  logic [47:0] spelling,
   input  logic [2:0]  spelling_length,
   output logic        match
);

   logic [KEY_DIGITS-1:0] lane_ok;
   logic [2:0]            spell_len;

   for (genvar i = 0; i < KEY_DIGITS; i++) begin : g_lane
      logic [3:0] want;
      logic [3:0] got;
      assign want = key_digits[4*i +: 4];
      assign got  = letter_digit(spelling[8*i +: 8]);
      // lanes past the key length do not vote
      assign lane_ok[i] = (3'(i) >= key_length) || ((got != 4'd0) && (got == want));
   end

   assign spell_len = (spelling_length > 3'(MAX_SPELLING)) ? 3'(MAX_SPELLING)
                                                            : spelling_length;

   assign match = (key_length != 3'd0) && (key_length <= 3'(KEY_DIGITS)) &&
                  (key_length <= spell_len) && (&lane_ok);

endmodule

[design/t9kc_seen_store.sv]
// candidate table with one compare lane per entry for the duplicate check
// depends on t9kc_pkg
module t9kc_seen_store
   import t9kc_pkg::*;
#(
   parameter int MAX_CANDIDATES = MAX_CANDIDATES_DEF,
   localparam int CNT_W = $clog2(MAX_CANDIDATES + 1),
   localparam int IDX_W = (MAX_CANDIDATES > 1) ? $clog2(MAX_CANDIDATES) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [IDX_W-1:0] wr_idx,
   input  logic [20:0]      wr_glyph,
   input  logic [CNT_W-1:0] fill_count,
   input  logic [20:0]      probe_glyph,
   output logic             dup
);

   logic [20:0]               seen_ff [MAX_CANDIDATES];
   logic [MAX_CANDIDATES-1:0] hit;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         seen_ff[wr_idx] <= wr_glyph;
      end
   end

   // only entries below the fill count have been written in this query
   for (genvar i = 0; i < MAX_CANDIDATES; i++) begin : g_lane
      assign hit[i] = (CNT_W'(i) < fill_count) && (seen_ff[i] == probe_glyph);
   end

   assign dup = |hit;

endmodule

[design/t9kc_merge.sv]
// merge stage: combines lane results with query counters and builds the result
// depends on t9kc_pkg (lane_result_type, result_type, ACTION_CLEAR)
module t9kc_merge
   import t9kc_pkg::*;
#(
   parameter int MAX_CANDIDATES = MAX_CANDIDATES_DEF,
   localparam int CNT_W = $clog2(MAX_CANDIDATES + 1),
   localparam int IDX_W = (MAX_CANDIDATES > 1) ? $clog2(MAX_CANDIDATES) : 1,
   localparam int CMP_W = (CNT_W > 6) ? CNT_W : 6
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             commit,
   input  lane_result_type  lane,
   input  logic [5:0]       char_limit,
   input  logic [7:0]       byte_budget,
   output logic [CNT_W-1:0] count,
   output logic             wr_en,
   output logic [IDX_W-1:0] wr_idx,
   output result_type       result
);

   logic [CNT_W-1:0] count_ff, count_in;
   logic [7:0]       bytes_ff, bytes_in;
   logic             stop_ff, stop_in;
   logic [CMP_W-1:0] limit;
   logic [9:0]       need;
   logic             eligible;
   logic             over;
   logic             take;

   always_comb begin
      limit = (CMP_W'(char_limit) > CMP_W'(MAX_CANDIDATES)) ? CMP_W'(MAX_CANDIDATES)
                                                            : CMP_W'(char_limit);
      eligible = (lane.action != ACTION_CLEAR) && !stop_ff && (limit != '0) &&
                 (byte_budget != 8'd0) && (lane.glyph != 21'd0) &&
                 (CMP_W'(count_ff) < limit) && lane.match && !lane.dup;
      // glyph bytes plus the terminator must stay below the budget
      need = 10'(bytes_ff) + 10'(lane.utf8_len) + 10'd1;
      over = need >= 10'(byte_budget);
      take = eligible && !over;

      count_in = count_ff;
      bytes_in = bytes_ff;
      stop_in  = stop_ff;
      if (lane.action == ACTION_CLEAR) begin
         count_in = '0;
         bytes_in = 8'd0;
         stop_in  = 1'b0;
      end else if (take) begin
         count_in = count_ff + CNT_W'(1);
         bytes_in = bytes_ff + 8'(lane.utf8_len);
      end else if (eligible) begin
         stop_in = 1'b1;
      end

      result.taken       = take;
      result.glyph_out   = take ? lane.glyph : 21'd0;
      result.slot        = take ? 5'(count_ff) : 5'd0;
      result.char_count  = 6'(count_in);
      result.bytes_used  = bytes_in;
      result.budget_stop = stop_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         bytes_ff <= 8'd0;
         stop_ff  <= 1'b0;
      end else if (commit) begin
         count_ff <= count_in;
         bytes_ff <= bytes_in;
         stop_ff  <= stop_in;
      end
   end

   assign count  = count_ff;
   assign wr_en  = commit && take;
   assign wr_idx = IDX_W'(count_ff);

endmodule

[design/t9_keypad_candidate_collector_core.sv]
// top level of the t9 keypad candidate collector
// depends on t9kc_pkg, t9kc_key_match, t9kc_seen_store, t9kc_merge
//
// Each request offers one dictionary glyph with its spelling, or clears the
// query, and gives exactly one result. A request passes through a lane stage,
// where one lane per key digit checks the spelling and one compare lane per
// candidate entry checks for a duplicate, and then a merge stage that updates
// the counters and the candidate table. The next request is taken in the merge
// cycle, so it overlaps the one that commits; a result waiting in the output
// register only holds the merge when a second result is due. The candidate
// table has no reset clear; only entries below the current count are compared.
// Registers are at byte addresses 0x0 key_digits, 0x4 key_length, 0x8
// char_limit and 0xc byte_budget and should be written while idle.
module t9_keypad_candidate_collector_core
   import t9kc_pkg::*;
#(
   parameter int MAX_CANDIDATES = MAX_CANDIDATES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,  // spelling[47:0], spelling_length[50:48], glyph[71:51]
   input  logic        req_tuser,  // action
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,  // glyph_out[20:0], slot[25:21], char_count[31:26],
                                   // bytes_used[39:32], budget_stop[40], zeros above
   output logic        rsp_tuser,  // taken
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int CNT_W = $clog2(MAX_CANDIDATES + 1);
   localparam int IDX_W = (MAX_CANDIDATES > 1) ? $clog2(MAX_CANDIDATES) : 1;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_LANE  = 2'd1;
   localparam logic [1:0] ST_MERGE = 2'd2;

   logic [1:0]       state_ff, state_in;
   logic [23:0]      key_digits_ff;
   logic [2:0]       key_length_ff;
   logic [5:0]       char_limit_ff;
   logic [7:0]       byte_budget_ff;
   logic             csr_write;

   logic             req_action_ff;
   logic [47:0]      req_spelling_ff;
   logic [2:0]       req_spell_len_ff;
   logic [20:0]      req_glyph_ff;

   lane_result_type  lane_ff, lane_in;
   logic             match;
   logic             dup;

   logic             accept;
   logic             out_free;
   logic             commit;
   logic [CNT_W-1:0] count;
   logic             wr_en;
   logic [IDX_W-1:0] wr_idx;
   result_type       result;

   logic             rsp_valid_ff;
   result_type       rsp_ff;

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_digits_ff  <= 24'd0;
         key_length_ff  <= 3'd0;
         char_limit_ff  <= CHAR_LIMIT_RST;
         byte_budget_ff <= BYTE_BUDGET_RST;
      end else if (csr_write) begin
         case (csr_paddr[3:2])
            CSR_KEY_DIGITS:  key_digits_ff  <= csr_pwdata[23:0];
            CSR_KEY_LENGTH:  key_length_ff  <= csr_pwdata[2:0];
            CSR_CHAR_LIMIT:  char_limit_ff  <= csr_pwdata[5:0];
            CSR_BYTE_BUDGET: byte_budget_ff <= csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         CSR_KEY_DIGITS:  csr_prdata = 32'(key_digits_ff);
         CSR_KEY_LENGTH:  csr_prdata = 32'(key_length_ff);
         CSR_CHAR_LIMIT:  csr_prdata = 32'(char_limit_ff);
         CSR_BYTE_BUDGET: csr_prdata = 32'(byte_budget_ff);
         default:         csr_prdata = 32'd0;
      endcase
   end

   // sequencing
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign commit     = (state_ff == ST_MERGE) && out_free;
   assign req_tready = (state_ff == ST_IDLE) || commit;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (accept) state_in = ST_LANE;
         ST_LANE:  state_in = ST_MERGE;
         ST_MERGE: if (commit) state_in = accept ? ST_LANE : ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_action_ff    <= req_tuser;
         req_spelling_ff  <= req_tdata[47:0];
         req_spell_len_ff <= req_tdata[50:48];
         req_glyph_ff     <= req_tdata[71:51];
      end
   end

   // lane stage
   t9kc_key_match u_key_match (
      .key_digits      (key_digits_ff),
      .key_length      (key_length_ff),
      .spelling        (req_spelling_ff),
      .spelling_length (req_spell_len_ff),
      .match           (match)
   );

   t9kc_seen_store #(
      .MAX_CANDIDATES (MAX_CANDIDATES)
   ) u_seen_store (
      .clock       (clock),
      .wr_en       (wr_en),
      .wr_idx      (wr_idx),
      .wr_glyph    (lane_ff.glyph),
      .fill_count  (count),
      .probe_glyph (req_glyph_ff),
      .dup         (dup)
   );

   always_comb begin
      lane_in.action   = req_action_ff;
      lane_in.glyph    = req_glyph_ff;
      lane_in.match    = match;
      lane_in.dup      = dup;
      lane_in.utf8_len = utf8_length(req_glyph_ff);
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_LANE) begin
         lane_ff <= lane_in;
      end
   end

   // merge stage
   t9kc_merge #(
      .MAX_CANDIDATES (MAX_CANDIDATES)
   ) u_merge (
      .clock       (clock),
      .reset       (reset),
      .commit      (commit),
      .lane        (lane_ff),
      .char_limit  (char_limit_ff),
      .byte_budget (byte_budget_ff),
      .count       (count),
      .wr_en       (wr_en),
      .wr_idx      (wr_idx),
      .result      (result)
   );

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         rsp_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.taken;
   assign rsp_tdata  = {7'd0, rsp_ff.budget_stop, rsp_ff.bytes_used, rsp_ff.char_count,
                        rsp_ff.slot, rsp_ff.glyph_out};

endmodule
